// ===== hdl/mpsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpsm_pkg: shared definitions for the multi-pattern string matcher
// Field widths, input mode codes and the packed per-node information entry.
// ----------------------------------------------------------------------------
package mpsm_pkg;

	localparam int MODE_W   = 2;
	localparam int NODE_W   = 10;
	localparam int LETTER_W = 5;
	localparam int WORD_W   = 10;
	localparam int LEN_W    = 5;
	localparam int START_W  = 21;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_CHILD = 2'd0,
		MODE_LOAD_INFO  = 2'd1,
		MODE_SCAN       = 2'd2,
		MODE_RESTART    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [NODE_W-1:0] suffix_link;
		logic [NODE_W-1:0] exit_ptr;
		logic              terminal;
		logic [WORD_W-1:0] word_id;
		logic [LEN_W-1:0]  word_len;
	} node_info_t;

endpackage
`default_nettype wire

// ===== hdl/mpsm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpsm_if: stream channels of the multi-pattern string matcher
// One interface for the command/letter words and one for the match words.
// ----------------------------------------------------------------------------
interface mpsm_cmd_if import mpsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [NODE_W-1:0]   node_index;
	logic [LETTER_W-1:0] letter;
	logic [NODE_W-1:0]   link_node;
	logic [NODE_W-1:0]   exit_node;
	logic                terminal;
	logic [WORD_W-1:0]   word_number;
	logic [LEN_W-1:0]    word_length;

	modport source (output valid, mode, node_index, letter, link_node, exit_node,
		terminal, word_number, word_length, input ready);
	modport sink (input valid, mode, node_index, letter, link_node, exit_node,
		terminal, word_number, word_length, output ready);
endinterface

interface mpsm_match_if import mpsm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  match_word;
	logic [START_W-1:0] match_start;
	logic               last;

	modport source (output valid, match_word, match_start, last, input ready);
	modport sink (input valid, match_word, match_start, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/mpsm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpsm_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mpsm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/multi_pattern_string_matcher.sv =====
`default_nettype none
// A load or restart word is taken in the idle state. A scan word passes an accept step,
// a goto lookup per step (one plus each suffix-link step, at most MAX_DEPTH + 1 lookups),
// a node check and then its match words (at most MAX_DEPTH match words).
// One word in flight: no new word is taken until the engine is back in idle, and a stalled
// match output holds it. The pace is bounded by the single read port of the goto and node-info memories.
// Reset: after arst_n the goto memory and terminal flags are swept before the first word is taken.
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher: Aho-Corasick matching engine
// Holds the automaton in a goto memory and a node-info memory loaded by the
// host, walks suffix links per letter and reports each match on the exit chain.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher import mpsm_pkg::*; #(
	parameter int NODES         = 1024,
	parameter int ALPHABET      = 26,
	parameter int MAX_DEPTH     = 16,
	parameter int POSITION_BITS = 20
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mpsm_cmd_if.sink   scan,
	mpsm_match_if.source match
);

	localparam int NW     = $clog2(NODES);
	localparam int GDEPTH = NODES * ALPHABET;
	localparam int GAW    = $clog2(GDEPTH);
	localparam int DW     = $clog2(MAX_DEPTH + 1);
	localparam int PW     = POSITION_BITS;
	localparam int SW     = (PW + 1 > START_W) ? PW + 1 : START_W;
	localparam int IW     = $bits(node_info_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHILD,
		S_TERM,
		S_INFO
	} state_t;

	// A stored node number outside the node range reads as the root.
	function automatic logic [NW-1:0] node_ok(input logic [NODE_W-1:0] v);
		logic [NW-1:0] r;
		r = '0;
		if (32'(v) < NODES) begin
			r = NW'(v);
		end
		return r;
	endfunction

	// Goto memory address of one (node, letter) entry: node times alphabet plus letter.
	function automatic logic [GAW-1:0] gaddr(input logic [NW-1:0] n,
		input logic [LETTER_W-1:0] l);
		return GAW'(n) * GAW'(ALPHABET) + GAW'(l);
	endfunction

	state_t              state_q;
	logic [GAW-1:0]      clr_q;
	logic [NW-1:0]       cur_q;
	logic [NW-1:0]       node_q;
	logic [LETTER_W-1:0] letter_q;
	logic [PW-1:0]       pos_q;
	logic [DW-1:0]       cnt_q;

	logic                   goto_we;
	logic [GAW-1:0]         goto_waddr;
	logic [NODE_W-1:0]      goto_wdata;
	logic [GAW-1:0]         goto_raddr;
	logic [NODE_W-1:0]      goto_rdata;
	logic                   info_we;
	logic [NW-1:0]          info_waddr;
	node_info_t             info_wdata;
	logic [NW-1:0]          info_raddr;
	logic [IW-1:0]          info_rbits;
	node_info_t             info_rd;

	logic          scan_acc;
	logic          out_free;
	logic          emit;
	logic          emit_last;
	logic [NW-1:0] child_c;
	logic [NW-1:0] sfx_c;
	logic [NW-1:0] exit_c;
	logic [SW-1:0] start_c;
	logic          idx_ok;
	logic          letter_ok;

	assign info_rd    = node_info_t'(info_rbits);
	assign scan.ready = (state_q == S_IDLE);
	assign scan_acc   = scan.valid && scan.ready;
	assign out_free   = !match.valid || match.ready;
	assign child_c    = node_ok(goto_rdata);
	assign sfx_c      = node_ok(info_rd.suffix_link);
	assign exit_c     = node_ok(info_rd.exit_ptr);
	assign idx_ok     = 32'(scan.node_index) < NODES;
	assign letter_ok  = 32'(scan.letter) < ALPHABET;
	assign emit       = (state_q == S_INFO) && out_free;
	assign emit_last  = (exit_c == '0) || (32'(cnt_q) + 1 == MAX_DEPTH);

	// Start position of the match: clamps to one when the word is longer than the text.
	always_comb begin
		if (SW'(info_rd.word_len) > SW'(pos_q)) begin
			start_c = SW'(1);
		end else begin
			start_c = SW'(pos_q) - SW'(info_rd.word_len) + SW'(1);
		end
	end

	// Memory write ports: the reset sweep, or the host loading table entries.
	always_comb begin
		goto_we    = 1'b0;
		goto_waddr = gaddr(NW'(scan.node_index), scan.letter);
		goto_wdata = scan.link_node;
		info_we    = 1'b0;
		info_waddr = NW'(scan.node_index);
		info_wdata = '{suffix_link: scan.link_node, exit_ptr: scan.exit_node,
			terminal: scan.terminal, word_id: scan.word_number, word_len: scan.word_length};
		if (state_q == S_CLEAR) begin
			// The sweep zeroes every goto entry and every node entry, which clears
			// the terminal flags; the other node fields are rewritten before use.
			goto_we    = 1'b1;
			goto_waddr = clr_q;
			goto_wdata = '0;
			info_we    = (32'(clr_q) < NODES);
			info_waddr = clr_q[NW-1:0];
			info_wdata = '0;
		end else if (scan_acc && scan.mode == MODE_LOAD_CHILD) begin
			goto_we = idx_ok && letter_ok;
		end else if (scan_acc && scan.mode == MODE_LOAD_INFO) begin
			info_we = idx_ok;
		end
	end

	// Read addresses. Each memory is read every cycle; holding the address holds
	// the registered read data, so a stalled match word keeps its node entry.
	always_comb begin
		goto_raddr = gaddr(node_q, letter_q);
		info_raddr = node_q;
		unique case (state_q)
			S_IDLE: begin
				goto_raddr = gaddr(cur_q, scan.letter);
				info_raddr = cur_q;
			end
			S_CHILD: begin
				if (node_q == '0 || child_c != '0) begin
					info_raddr = (node_q == '0) ? child_c : child_c;
				end else if (sfx_c == '0 || 32'(cnt_q) + 1 == MAX_DEPTH) begin
					goto_raddr = gaddr('0, letter_q);
				end else begin
					goto_raddr = gaddr(sfx_c, letter_q);
					info_raddr = sfx_c;
				end
			end
			S_TERM: begin
				if (!info_rd.terminal) begin
					info_raddr = exit_c;
				end
			end
			S_INFO: begin
				if (emit && !emit_last) begin
					info_raddr = exit_c;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer: one word at a time, with the match output register in front.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_CLEAR;
			clr_q             <= '0;
			cur_q             <= '0;
			node_q            <= '0;
			letter_q          <= '0;
			pos_q             <= '0;
			cnt_q             <= '0;
			match.valid       <= 1'b0;
			match.match_word  <= '0;
			match.match_start <= '0;
			match.last        <= 1'b0;
		end else begin
			// A new match word replaces the one just taken in the same cycle.
			if (match.valid && match.ready && !emit) begin
				match.valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GAW'(1);
					if (clr_q == GAW'(GDEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (scan_acc) begin
						unique case (mode_t'(scan.mode))
							MODE_RESTART: begin
								cur_q <= '0;
								pos_q <= '0;
							end
							MODE_SCAN: begin
								if (pos_q != '1) begin
									pos_q <= pos_q + PW'(1);
								end
								letter_q <= scan.letter;
								node_q   <= cur_q;
								cnt_q    <= '0;
								if (letter_ok) begin
									state_q <= S_CHILD;
								end else begin
									// No node has a child for this letter: back to the root.
									cur_q <= '0;
								end
							end
							MODE_LOAD_CHILD, MODE_LOAD_INFO: begin
							end
							default: begin
							end
						endcase
					end
				end
				S_CHILD: begin
					if (node_q == '0 || child_c != '0) begin
						// The root lookup, or a child found: this is the new node.
						cur_q  <= child_c;
						node_q <= child_c;
						cnt_q  <= '0;
						state_q <= (child_c == '0) ? S_IDLE : S_TERM;
					end else if (sfx_c == '0 || 32'(cnt_q) + 1 == MAX_DEPTH) begin
						node_q <= '0;
					end else begin
						node_q <= sfx_c;
						cnt_q  <= cnt_q + DW'(1);
					end
				end
				S_TERM: begin
					// A terminal node reports itself first; otherwise start at its exit link.
					if (info_rd.terminal) begin
						state_q <= S_INFO;
					end else if (exit_c == '0) begin
						state_q <= S_IDLE;
					end else begin
						node_q  <= exit_c;
						state_q <= S_INFO;
					end
				end
				S_INFO: begin
					if (emit) begin
						match.valid       <= 1'b1;
						match.match_word  <= info_rd.word_id;
						match.match_start <= START_W'(start_c);
						match.last        <= emit_last;
						cnt_q             <= cnt_q + DW'(1);
						node_q            <= exit_c;
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	mpsm_ram #(
		.WIDTH (NODE_W),
		.DEPTH (GDEPTH)
	) u_goto_ram (
		.clk   (clk),
		.we    (goto_we),
		.waddr (goto_waddr),
		.wdata (goto_wdata),
		.raddr (goto_raddr),
		.rdata (goto_rdata)
	);

	mpsm_ram #(
		.WIDTH (IW),
		.DEPTH (NODES)
	) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (info_waddr),
		.wdata (IW'(info_wdata)),
		.raddr (info_raddr),
		.rdata (info_rbits)
	);

	// The current node always lies inside the node range.
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < NODES)
		else $error("current node out of range");

	// The suffix-step and match count per letter never passes the depth limit.
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_DEPTH)
		else $error("match count beyond depth limit");

	// After the final match of a letter the engine takes the next word.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == S_IDLE)
		else $error("engine busy after final match");

	// No match word and no input word during the reset sweep.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !match.valid && !scan.ready)
		else $error("activity during memory sweep");

endmodule
`default_nettype wire

// ===== dv/mpsm_match_checker.sv =====
// ----------------------------------------------------------------------------
// mpsm_match_checker: match predictor and scoreboard
// Watches both channels and mirrors the automaton tables from the load words.
// Works out the matches of each letter and compares every match word in order.
// ----------------------------------------------------------------------------
module mpsm_match_checker import mpsm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mpsm_cmd_if       scan,
	mpsm_match_if     match,
	output int        errors,
	output int        pending,
	output int        matches_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES     = 1024;
	localparam int ALPHABET  = 26;
	localparam int MAX_DEPTH = 16;
	localparam logic [19:0] POS_MAX = 20'hFFFFF;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [START_W-1:0] start;
		logic               last;
	} match_t;

	logic [NODE_W-1:0] goto_mem [NODES*ALPHABET];
	logic [NODE_W-1:0] suffix_mem [NODES];
	logic [NODE_W-1:0] exit_mem [NODES];
	logic              term_mem [NODES];
	logic [WORD_W-1:0] word_mem [NODES];
	logic [LEN_W-1:0]  len_mem [NODES];
	logic [NODE_W-1:0] cur_node;
	logic [19:0]       text_pos;
	match_t            expected_matches [$];

	function automatic logic [NODE_W-1:0] child_of(logic [NODE_W-1:0] node,
			logic [LETTER_W-1:0] letter);
		if (letter >= ALPHABET)
			return '0;
		return goto_mem[node*ALPHABET + letter];
	endfunction

	// Advances the automaton by one letter and queues every match it causes.
	function automatic void scan_letter(logic [LETTER_W-1:0] letter);
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] nxt;
		logic [NODE_W-1:0] c;
		logic              found;
		int                cnt;
		match_t            m;
		if (text_pos < POS_MAX)
			text_pos++;
		node  = cur_node;
		nxt   = '0;
		found = 1'b0;
		for (int step = 0; step < MAX_DEPTH; step++) begin
			if (node == 0)
				break;
			c = child_of(node, letter);
			if (c != 0) begin
				nxt   = c;
				found = 1'b1;
				break;
			end
			node = suffix_mem[node];
		end
		if (!found)
			nxt = child_of('0, letter);
		cur_node = nxt;
		node = cur_node;
		if (node != 0 && !term_mem[node])
			node = exit_mem[node];
		cnt = 0;
		while (node != 0 && cnt < MAX_DEPTH) begin
			m.word  = word_mem[node];
			m.start = (len_mem[node] > text_pos) ? START_W'(1)
				: START_W'(text_pos) - START_W'(len_mem[node]) + START_W'(1);
			m.last  = 1'b0;
			expected_matches.push_back(m);
			cnt++;
			node = exit_mem[node];
		end
		if (cnt > 0)
			expected_matches[$].last = 1'b1;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		match_t m;
		if (!arst_n) begin
			foreach (goto_mem[i]) goto_mem[i] = '0;
			foreach (term_mem[i]) begin
				term_mem[i]   = 1'b0;
				suffix_mem[i] = '0;
				exit_mem[i]   = '0;
				word_mem[i]   = '0;
				len_mem[i]    = '0;
			end
			cur_node = '0;
			text_pos = '0;
			errors = 0;
			matches_seen = 0;
			expected_matches.delete();
		end else begin
			if (match.valid && match.ready) begin
				matches_seen++;
				if (expected_matches.size() == 0) begin
					report("unexpected match word", 32'(match.match_word), 32'd0);
				end else begin
					m = expected_matches.pop_front();
					if (match.match_word !== m.word)
						report("match_word", 32'(match.match_word), 32'(m.word));
					if (match.match_start !== m.start)
						report("match_start", 32'(match.match_start), 32'(m.start));
					if (match.last !== m.last)
						report("last", 32'(match.last), 32'(m.last));
				end
			end
			if (scan.valid && scan.ready) begin
				case (mode_t'(scan.mode))
					MODE_LOAD_CHILD: begin
						if (scan.letter < ALPHABET)
							goto_mem[scan.node_index*ALPHABET + scan.letter] = scan.link_node;
					end
					MODE_LOAD_INFO: begin
						suffix_mem[scan.node_index] = scan.link_node;
						exit_mem[scan.node_index]   = scan.exit_node;
						term_mem[scan.node_index]   = scan.terminal;
						word_mem[scan.node_index]   = scan.word_number;
						len_mem[scan.node_index]    = scan.word_length;
					end
					MODE_SCAN: scan_letter(scan.letter);
					MODE_RESTART: begin
						cur_node = '0;
						text_pos = '0;
					end
				endcase
			end
		end
		pending = expected_matches.size();
	end
endmodule

// ===== dv/multi_pattern_string_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_tb: stimulus and verdict for the string matcher
// Loads a small hand-built dictionary, then random automata scanned with
// random text, with random gaps and stalls; the checker judges every match.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_tb;
	import mpsm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The limit covers the reset sweep and letters that each cost a goto walk plus
	// up to 16 match words, each of which may wait out a stall.
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   matches_seen;
	int   cycles = 0;
	int   letters_sent;
	int   loads_sent;
	int   rx_mode;      // 0 always ready, 1 random stalls, 2 one long hold-off
	bit   tx_steady;    // when set the sender offers words back to back
	int   known_nodes [$];

	mpsm_cmd_if   scan_if ();
	mpsm_match_if match_if ();

	multi_pattern_string_matcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_if),
		.match  (match_if)
	);

	mpsm_match_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan         (scan_if),
		.match        (match_if),
		.errors       (errors),
		.pending      (pending),
		.matches_seen (matches_seen)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d matches still outstanding", pending);
			$display("FAIL");
			$finish;
		end
	end

	// Most gaps are short; now and then one is long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// The match receiver. The long hold-off counts its own cycles so that the
	// sender keeps offering letters and the block has to stall its input.
	always @(negedge clk) begin
		int stall;
		bit held;
		if (!arst_n) begin
			match_if.ready = 1'b0;
			stall = 0;
			held = 1'b0;
		end else if (rx_mode == 2 && !held) begin
			match_if.ready = 1'b0;
			stall++;
			if (stall >= 400) begin
				stall = 0;
				held = 1'b1;
			end
		end else if (stall > 0) begin
			match_if.ready = 1'b0;
			stall--;
		end else if (rx_mode != 0 && $urandom_range(0, 3) == 0) begin
			match_if.ready = 1'b0;
			stall = gap_len();
		end else begin
			match_if.ready = 1'b1;
		end
	end

	// Offers one word and holds it until the block takes it. Called at a
	// falling edge; returns at the falling edge after the accept.
	task automatic put_word(mode_t m, logic [NODE_W-1:0] idx, logic [LETTER_W-1:0] letter,
			logic [NODE_W-1:0] link, logic [NODE_W-1:0] ex, logic term,
			logic [WORD_W-1:0] word, logic [LEN_W-1:0] len);
		int gap;
		gap = tx_steady ? 0 : gap_len();
		if (gap > 0) begin
			scan_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		scan_if.mode        = m;
		scan_if.node_index  = idx;
		scan_if.letter      = letter;
		scan_if.link_node   = link;
		scan_if.exit_node   = ex;
		scan_if.terminal    = term;
		scan_if.word_number = word;
		scan_if.word_length = len;
		scan_if.valid       = 1'b1;
		do
			@(posedge clk);
		while (!scan_if.ready);
		@(negedge clk);
		if (m == MODE_SCAN)
			letters_sent++;
		else
			loads_sent++;
	endtask

	// Node info for node n; its links point only at nodes already loaded, at
	// itself or at the root, so no unwritten entry is ever walked.
	task automatic load_node(logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] links [2];
		foreach (links[i]) begin
			case ($urandom_range(0, 7))
				0, 1, 2: links[i] = '0;
				3:       links[i] = n;
				default: links[i] = (known_nodes.size() == 0) ? NODE_W'(0)
					: NODE_W'(known_nodes[$urandom_range(0, known_nodes.size()-1)]);
			endcase
		end
		put_word(MODE_LOAD_INFO, n, LETTER_W'($urandom), links[0], links[1], 1'($urandom),
			WORD_W'($urandom), LEN_W'($urandom));
		known_nodes.push_back(n);
	endtask

	// One random word: mostly letters from a small alphabet over the loaded
	// automaton, with some goto writes, node loads, restarts and out-of-range noise.
	task automatic random_word();
		int r;
		logic [NODE_W-1:0] target;
		r = $urandom_range(0, 99);
		target = NODE_W'(known_nodes[$urandom_range(0, known_nodes.size()-1)]);
		if (r < 65)
			put_word(MODE_SCAN, NODE_W'($urandom),
				($urandom_range(0, 9) == 0) ? LETTER_W'($urandom) : LETTER_W'($urandom_range(0, 3)),
				NODE_W'($urandom), NODE_W'($urandom), 1'($urandom), WORD_W'($urandom),
				LEN_W'($urandom));
		else if (r < 82)
			put_word(MODE_LOAD_CHILD,
				($urandom_range(0, 3) == 0) ? NODE_W'($urandom) : target,
				($urandom_range(0, 7) == 0) ? LETTER_W'($urandom) : LETTER_W'($urandom_range(0, 3)),
				($urandom_range(0, 5) == 0) ? NODE_W'(0)
					: NODE_W'(known_nodes[$urandom_range(0, known_nodes.size()-1)]),
				NODE_W'($urandom), 1'($urandom), WORD_W'($urandom), LEN_W'($urandom));
		else if (r < 92)
			load_node(NODE_W'($urandom));
		else
			put_word(MODE_RESTART, NODE_W'($urandom), LETTER_W'($urandom), NODE_W'($urandom),
				NODE_W'($urandom), 1'($urandom), WORD_W'($urandom), LEN_W'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		letters_sent = 0;
		loads_sent = 0;
		rx_mode = 0;
		tx_steady = 1'b1;
		scan_if.valid = 1'b0;
		scan_if.mode = MODE_RESTART;
		scan_if.node_index = '0;
		scan_if.letter = '0;
		scan_if.link_node = '0;
		scan_if.exit_node = '0;
		scan_if.terminal = 1'b0;
		scan_if.word_number = '0;
		scan_if.word_length = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Dictionary {ab, b}: node 1 = a, node 2 = ab, node 3 = b, with the
		// suffix and exit links of node 2 pointing at node 3.
		put_word(MODE_LOAD_INFO, 1, 0, 0, 0, 1'b0, 0, 1);
		put_word(MODE_LOAD_INFO, 3, 0, 0, 0, 1'b1, 2, 1);
		put_word(MODE_LOAD_INFO, 2, 0, 3, 3, 1'b1, 1, 2);
		put_word(MODE_LOAD_CHILD, 0, 0, 1, 0, 1'b0, 0, 0);
		put_word(MODE_LOAD_CHILD, 1, 1, 2, 0, 1'b0, 0, 0);
		put_word(MODE_LOAD_CHILD, 0, 1, 3, 0, 1'b0, 0, 0);
		put_word(MODE_SCAN, 0, 0, 0, 0, 1'b0, 0, 0);
		// Two matches on one letter: ab via the terminal node, b via its exit.
		put_word(MODE_SCAN, 0, 1, 0, 0, 1'b0, 0, 0);
		// No child of b under ab: fall back through the suffix chain.
		put_word(MODE_SCAN, 0, 1, 0, 0, 1'b0, 0, 0);
		// A goto write with a letter past the alphabet is dropped.
		put_word(MODE_LOAD_CHILD, 0, 31, 2, 0, 1'b0, 0, 0);
		put_word(MODE_SCAN, 0, 31, 0, 0, 1'b0, 0, 0);
		// Node 1023 is its own suffix and exit link: each z yields the longest
		// exit chain, and the 16-letter word is longer than the text so far.
		put_word(MODE_LOAD_INFO, 1023, 0, 1023, 1023, 1'b1, 1023, 16);
		put_word(MODE_LOAD_CHILD, 0, 25, 1023, 0, 1'b0, 0, 0);
		put_word(MODE_RESTART, 0, 0, 0, 0, 1'b0, 0, 0);
		put_word(MODE_SCAN, 0, 25, 0, 0, 1'b0, 0, 0);
		put_word(MODE_SCAN, 0, 25, 0, 0, 1'b0, 0, 0);
		// A zero word length puts the start one past the current position.
		put_word(MODE_LOAD_INFO, 1, 0, 0, 0, 1'b1, 0, 0);
		put_word(MODE_RESTART, 0, 0, 0, 0, 1'b0, 0, 0);
		put_word(MODE_SCAN, 0, 0, 0, 0, 1'b0, 0, 0);
		known_nodes = '{1, 2, 3, 1023};

		// Random phases over growing automata.
		for (int phase = 0; phase < 4; phase++) begin
			tx_steady = (phase == 0);
			rx_mode = (phase == 0) ? 0 : 1;
			repeat (6) load_node(NODE_W'($urandom_range(1, 1023)));
			if (phase == 2) begin
				// Hold the receiver off while letters keep coming, so the
				// block fills up and has to stall its input.
				rx_mode = 2;
				tx_steady = 1'b1;
			end
			repeat (34) random_word();
			if (phase == 1) begin
				// The sender pauses until every match has drained.
				scan_if.valid = 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
		end
		scan_if.valid = 1'b0;

		wait (pending == 0);
		repeat (60) @(negedge clk);
		$display("run covered %0d letters and %0d table or restart words", letters_sent,
			loads_sent);
		$display("%0d match words checked, %0d mismatches", matches_seen, errors);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/mpsm_pkg.sv
hdl/mpsm_if.sv
hdl/mpsm_ram.sv
hdl/multi_pattern_string_matcher.sv
dv/mpsm_match_checker.sv
dv/multi_pattern_string_matcher_tb.sv
